// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Implication checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- src/trsm_pkg.sv -----
// Package for the triangular solver: sizes, codes and the sequencer states.
package trsm_pkg;
  localparam int MaxOrder = 16;
  localparam int MaxRhs   = 16;
  localparam int RowW     = 4;
  localparam int ColW     = 4;
  localparam int AAddrW   = 8;
  localparam int BAddrW   = 8;

  typedef enum logic [1:0] {
    OP_WR_A = 2'd0,
    OP_WR_B = 2'd1,
    OP_SOLVE = 2'd2,
    OP_RD_X = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_SINGULAR = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_LOWER = 2'd0,
    CFG_UNIT = 2'd1,
    CFG_ORDER = 2'd2,
    CFG_RHS = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_RESULT,
    S_ROW,
    S_DIAG,
    S_COL,
    S_COLWAIT,
    S_MAC_ISSUE,
    S_MAC_MUL,
    S_MAC_ACC,
    S_DIV,
    S_WRITE,
    S_DONE
  } state_t;
endpackage

// ----- src/trsm_div.sv -----
// Restoring divider: a signed 64 by 32 quotient, one bit per cycle, saturated to 32 bits.
module trsm_div import trsm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] dividend,
  input  logic signed [31:0] divisor,
  output logic               done,
  output logic signed [31:0] quotient
);
  logic [63:0] num;
  logic [31:0] den;
  logic [64:0] rem;
  logic [63:0] quo;
  logic [6:0]  count;
  logic        busy;
  logic        neg;
  logic [64:0] trial;
  logic signed [64:0] sq;

  assign trial = {rem[63:0], num[63]} - {33'd0, den};

  // Sign and magnitude up front, then one quotient bit each cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        num   <= dividend[63] ? 64'(-dividend) : dividend;
        den   <= divisor[31] ? 32'(-divisor) : divisor;
        neg   <= dividend[63] ^ divisor[31];
        rem   <= '0;
        quo   <= '0;
        count <= 7'd0;
      end else if (busy) begin
        if (!trial[64]) begin
          rem <= trial;
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[63:0], num[63]};
          quo <= {quo[62:0], 1'b0};
        end
        num   <= {num[62:0], 1'b0};
        count <= count + 7'd1;
        if (count == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Apply the sign and clamp to the 32-bit range.
  always_comb begin
    sq = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    if (sq > 65'sd2147483647) quotient = 32'sh7fffffff;
    else if (sq < -65'sd2147483648) quotient = 32'sh80000000;
    else quotient = sq[31:0];
  end
endmodule

// ----- src/triangular_solve_multi_rhs.sv -----
// Triangular solver top level: request decode, two entry memories, solve sequencer.
// A write or read request passes S_READ and S_RESULT through one port of the
// addressed memory, and the block is idle again once its result is loaded. A
// solve walks the matrix with one multiplier and one 64-step divider, one
// memory read pair at a time: each product passes S_MAC_ISSUE, S_MAC_MUL and
// S_MAC_ACC, each row and column then passes S_DIV for the divide (skipped
// with a unit or zero diagonal) and S_WRITE, and each row opens with S_ROW
// and S_DIAG. The block takes no request while one is in work. A finished
// result waits in the output register while the next request is taken; that
// request's own result is held back until the register is free.
module triangular_solve_multi_rhs import trsm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // row_index[3:0], col_index[7:4], entry_value[39:8]
  input  logic [1:0]  s_axis_tuser,  // operation[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // read_value[31:0]
  output logic [1:0]  m_axis_tuser,  // status[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);
  logic        lower_triangle, unit_diagonal, singular;
  logic [4:0]  matrix_order, rhs_columns;
  logic [4:0]  n_eff, m_eff;
  state_t      state, state_next;

  logic [31:0] a_mem [MaxOrder*MaxOrder];
  logic [31:0] b_mem [MaxOrder*MaxRhs];
  logic [31:0] a_q, b_q;
  logic [AAddrW-1:0] a_raddr;
  logic [BAddrW-1:0] b_raddr;
  logic        b_we;
  logic [BAddrW-1:0] b_waddr;
  logic [31:0] b_wdata;

  op_t         op;
  logic [RowW-1:0] req_row;
  logic [ColW-1:0] req_col;
  logic [31:0] req_val;
  logic        req_ok;

  logic [4:0]  step, kidx, cidx;
  logic [RowW-1:0] irow;
  logic [31:0] diag;
  logic signed [51:0] acc;
  logic signed [31:0] opa, opb;
  logic        stop_row;
  logic signed [31:0] acc_sat;
  logic        div_start, div_done;
  logic signed [31:0] div_q;
  logic [31:0] wr_val;
  logic        accept;
  logic        out_free;
  logic [4:0]  klo, khi;

  assign cfg_ready = 1'b1;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Clamp the order and column counts to their usable range.
  assign n_eff = (matrix_order == 5'd0) ? 5'd1 :
                 (matrix_order > 5'(MaxOrder)) ? 5'(MaxOrder) : matrix_order;
  assign m_eff = (rhs_columns == 5'd0) ? 5'd1 :
                 (rhs_columns > 5'(MaxRhs)) ? 5'(MaxRhs) : rhs_columns;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      lower_triangle <= 1'b0;
      unit_diagonal  <= 1'b0;
      matrix_order   <= 5'd16;
      rhs_columns    <= 5'd16;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LOWER: lower_triangle <= cfg_data[0];
        CFG_UNIT:  unit_diagonal  <= cfg_data[0];
        CFG_ORDER: matrix_order   <= cfg_data;
        CFG_RHS:   rhs_columns    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the request.
  always_ff @(posedge clk) begin
    if (accept) begin
      op      <= op_t'(s_axis_tuser);
      req_row <= s_axis_tdata[3:0];
      req_col <= s_axis_tdata[7:4];
      req_val <= s_axis_tdata[39:8];
    end
  end

  // The addressed entry lies inside the matrix for A, inside the used columns otherwise.
  assign req_ok = ({1'b0, req_row} < n_eff)
                  && ({1'b0, req_col} < ((op == OP_WR_A) ? n_eff : m_eff));

  // Products accumulate with the row in a wide register; bounds of the inner loop.
  assign klo = lower_triangle ? 5'd0 : 5'({1'b0, irow} + 5'd1);
  assign khi = lower_triangle ? 5'({1'b0, irow}) : n_eff;
  assign acc_sat = (acc > 52'sd2147483647) ? 32'sh7fffffff :
                   (acc < -52'sd2147483648) ? 32'sh80000000 : acc[31:0];

  // Memory read addresses follow the sequencer.
  always_comb begin
    a_raddr = {req_row, req_col};
    b_raddr = {req_row, req_col};
    case (state)
      S_ROW:       a_raddr = {irow, irow};
      S_COL:       b_raddr = {irow, cidx[3:0]};
      S_MAC_ISSUE: begin
        a_raddr = {irow, kidx[3:0]};
        b_raddr = {kidx[3:0], cidx[3:0]};
      end
      default: ;
    endcase
  end

  // One write port on the right-hand side memory: loads and solved entries.
  assign b_we    = (state == S_WRITE) || (state == S_READ && op == OP_WR_B && req_ok);
  assign b_waddr = (state == S_WRITE) ? {irow, cidx[3:0]} : {req_row, req_col};
  assign b_wdata = (state == S_WRITE) ? wr_val : req_val;

  // Memories with registered reads.
  always_ff @(posedge clk) begin
    a_q <= a_mem[a_raddr];
    b_q <= b_mem[b_raddr];
    if (state == S_READ && op == OP_WR_A && req_ok)
      a_mem[{req_row, req_col}] <= req_val;
    if (b_we)
      b_mem[b_waddr] <= b_wdata;
  end

  trsm_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend({{16{acc_sat[31]}}, acc_sat, 16'd0}),
    .divisor(diag), .done(div_done), .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (accept) state_next = (s_axis_tuser == OP_SOLVE) ? S_ROW : S_READ;
      S_READ:      state_next = S_RESULT;
      S_RESULT:    state_next = out_free ? S_IDLE : S_RESULT;
      S_ROW:       state_next = S_DIAG;
      S_DIAG:      state_next = S_COL;
      S_COL:       state_next = S_COLWAIT;
      S_COLWAIT:   state_next = (kidx < khi) ? S_MAC_ISSUE : S_DIV;
      S_MAC_ISSUE: state_next = S_MAC_MUL;
      S_MAC_MUL:   state_next = S_MAC_ACC;
      S_MAC_ACC:   state_next = (kidx < khi) ? S_MAC_ISSUE : S_DIV;
      S_DIV: begin
        if (unit_diagonal || stop_row) state_next = S_WRITE;
        else if (div_done) state_next = S_WRITE;
      end
      S_WRITE: begin
        if (5'(cidx + 5'd1) < m_eff) state_next = S_COL;
        else if (stop_row || 5'(step + 5'd1) >= n_eff) state_next = S_DONE;
        else state_next = S_ROW;
      end
      S_DONE:      state_next = out_free ? S_IDLE : S_DONE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Solve datapath and result register: one multiplier, one accumulator and the shared divider.
  logic div_go;
  always_ff @(posedge clk) begin
    if (rst) begin
      singular <= 1'b0;
      m_axis_tvalid <= 1'b0;
      div_go <= 1'b0;
    end else begin
      // The result register loads only when it is empty or being emptied.
      if ((state == S_RESULT || state == S_DONE) && out_free) m_axis_tvalid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      div_go <= (state == S_DIV) && !unit_diagonal && !stop_row && !div_done && !div_go;
      case (state)
        S_IDLE: begin
          step <= 5'd0;
          irow <= lower_triangle ? 4'd0 : 4'(n_eff - 5'd1);
        end
        S_RESULT: begin
          if (out_free) begin
            m_axis_tdata <= (op == OP_RD_X && req_ok) ? b_q : 32'd0;
            m_axis_tuser <= !req_ok ? ST_RANGE :
                            (op == OP_RD_X && singular) ? ST_SINGULAR : ST_OK;
          end
        end
        S_ROW:  cidx <= 5'd0;
        S_DIAG: begin
          diag <= a_q;
          stop_row <= !unit_diagonal && (a_q == 32'd0);
        end
        S_COL:  kidx <= klo;
        S_COLWAIT: acc <= 52'(signed'(b_q));
        S_MAC_ISSUE: kidx <= kidx + 5'd1;
        S_MAC_MUL: begin
          opa <= a_q;
          opb <= b_q;
        end
        S_MAC_ACC: acc <= acc - 52'((64'(opa * opb) + 64'sd32768) >>> 16);
        S_DIV: begin
          if (unit_diagonal || stop_row) wr_val <= acc_sat;
          else if (div_done) wr_val <= div_q;
        end
        S_WRITE: begin
          cidx <= cidx + 5'd1;
          if (5'(cidx + 5'd1) >= m_eff) begin
            step <= step + 5'd1;
            irow <= lower_triangle ? 4'(irow + 4'd1) : 4'(irow - 4'd1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            singular <= stop_row;
            m_axis_tdata  <= 32'd0;
            m_axis_tuser  <= stop_row ? ST_SINGULAR : ST_OK;
          end
        end
        default: ;
      endcase
    end
  end

  // At most one divide request per row and column, none with a unit or zero diagonal.
  logic div_seen;
  always_ff @(posedge clk) begin
    if (rst || state != S_DIV) div_seen <= 1'b0;
    else if (div_go) div_seen <= 1'b1;
  end
  assign div_start = div_go && !div_seen;
endmodule

// ----- src/trsm_checker.sv -----
// Port checker for the triangular solver, bound to the top level.
`include "assert_macros.svh"
module trsm_checker import trsm_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  `CHK_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
  `CHK_NEXT(a_busy_after_take, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready after request")
  `CHK_IMPLY(a_status_code, clk, rst, m_axis_tvalid, m_axis_tuser != 2'd3, "status code out of range")
  `CHK_IMPLY(a_range_zero, clk, rst, m_axis_tvalid && m_axis_tuser == ST_RANGE, m_axis_tdata == 32'd0, "range error with data")
endmodule

bind triangular_solve_multi_rhs trsm_checker u_trsm_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
